// ===== hdl/ipid2_pkg.sv =====
package ipid2_pkg;

  localparam int SampleW = 16;
  localparam int ErrW    = SampleW + 1;
  localparam int GainW   = 16;
  localparam int StepW   = 17;
  localparam int DutyW   = 16;
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 17;

  typedef enum logic [CfgAddrW-1:0] {
    REG_SETPOINT         = 3'd0,
    REG_GAIN_NOW         = 3'd1,
    REG_GAIN_LAST        = 3'd2,
    REG_GAIN_BEFORE_LAST = 3'd3,
    REG_STEP_MAX         = 3'd4,
    REG_STEP_MIN         = 3'd5,
    REG_DUTY_MAX         = 3'd6,
    REG_DUTY_MIN         = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SampleW-1:0] setpoint;
    logic signed [GainW-1:0]   gain_now;
    logic signed [GainW-1:0]   gain_last;
    logic signed [GainW-1:0]   gain_before_last;
    logic signed [StepW-1:0]   step_max;
    logic signed [StepW-1:0]   step_min;
    logic        [DutyW-1:0]   duty_max;
    logic        [DutyW-1:0]   duty_min;
  } cfg_t;

  // loop state carried from one sample to the next
  typedef struct packed {
    logic signed [ErrW-1:0] err_prev1;
    logic signed [ErrW-1:0] err_prev2;
    logic        [DutyW-1:0] acc_a;
    logic        [DutyW-1:0] acc_b;
  } loop_state_t;

endpackage

// ===== hdl/ipid2_calc.sv =====
module ipid2_calc
  import ipid2_pkg::*;
(
  input  cfg_t                      cfg,
  input  loop_state_t               state_cur,
  input  logic signed [SampleW-1:0] measured,
  output loop_state_t               state_nxt
);

  localparam int ProdW = ErrW + GainW;
  localparam int RawW  = ProdW + 2;
  localparam int IncW  = RawW - 8;
  localparam int NegW  = IncW + 1;
  localparam int SumW  = DutyW + 3;

  logic signed [ErrW-1:0]  err;
  logic signed [ProdW-1:0] p_now;
  logic signed [ProdW-1:0] p_last;
  logic signed [ProdW-1:0] p_before;
  logic signed [RawW-1:0]  raw;
  logic signed [RawW-1:0]  raw_adj;
  logic signed [IncW-1:0]  inc;
  logic signed [NegW-1:0]  inc_pos;
  logic signed [NegW-1:0]  inc_neg;
  logic signed [StepW-1:0] step_a;
  logic signed [StepW-1:0] step_b;

  function automatic logic signed [StepW-1:0] clamp_step(
    input logic signed [NegW-1:0]  v,
    input logic signed [StepW-1:0] hi,
    input logic signed [StepW-1:0] lo
  );
    logic signed [NegW-1:0] hi_x;
    logic signed [NegW-1:0] lo_x;
    hi_x = {{(NegW-StepW){hi[StepW-1]}}, hi};
    lo_x = {{(NegW-StepW){lo[StepW-1]}}, lo};
    // upper test wins when the limits are inverted
    if (v > hi_x) begin
      clamp_step = hi;
    end else if (v < lo_x) begin
      clamp_step = lo;
    end else begin
      clamp_step = v[StepW-1:0];
    end
  endfunction

  function automatic logic [DutyW-1:0] sat_duty(
    input logic        [DutyW-1:0] acc,
    input logic signed [StepW-1:0] step,
    input logic        [DutyW-1:0] hi,
    input logic        [DutyW-1:0] lo
  );
    logic signed [SumW-1:0] sum;
    logic signed [SumW-1:0] hi_x;
    logic signed [SumW-1:0] lo_x;
    sum  = $signed({3'b000, acc}) + $signed({{(SumW-StepW){step[StepW-1]}}, step});
    hi_x = $signed({3'b000, hi});
    lo_x = $signed({3'b000, lo});
    if (sum >= hi_x) begin
      sat_duty = hi;
    end else if (sum <= lo_x) begin
      sat_duty = lo;
    end else begin
      sat_duty = sum[DutyW-1:0];
    end
  endfunction

  always_comb begin
    err = $signed({cfg.setpoint[SampleW-1], cfg.setpoint})
        - $signed({measured[SampleW-1], measured});

    p_now    = err * cfg.gain_now;
    p_last   = state_cur.err_prev1 * cfg.gain_last;
    p_before = state_cur.err_prev2 * cfg.gain_before_last;

    raw = $signed({{2{p_now[ProdW-1]}}, p_now})
        - $signed({{2{p_last[ProdW-1]}}, p_last})
        + $signed({{2{p_before[ProdW-1]}}, p_before});

    // bias negative sums so the shift rounds toward zero
    raw_adj = raw + (raw[RawW-1] ? RawW'(255) : RawW'(0));
    inc     = raw_adj[RawW-1:8];
    inc_pos = {inc[IncW-1], inc};
    inc_neg = -inc_pos;

    step_a = clamp_step(inc_pos, cfg.step_max, cfg.step_min);
    step_b = clamp_step(inc_neg, cfg.step_max, cfg.step_min);

    state_nxt.err_prev2 = state_cur.err_prev1;
    state_nxt.err_prev1 = err;
    state_nxt.acc_a = sat_duty(state_cur.acc_a, step_a, cfg.duty_max, cfg.duty_min);
    state_nxt.acc_b = sat_duty(state_cur.acc_b, step_b, cfg.duty_max, cfg.duty_min);
  end

endmodule

// ===== hdl/incremental_pid_two_channel.sv =====
// Two-channel incremental PID drive. Each transfer on the in_ stream is one
// measured sample; each produces exactly one out_ transfer carrying both
// saturated drive values. A sample is registered on entry and finished by the
// combinational error/gain datapath, so one sample is taken every clock while
// out_ does not stall; its result is loaded into the output register when that
// register is free, and the output register lets the next sample enter while a
// result waits. The user must write gains, limits and setpoint through the cfg_
// port only while no sample is in flight; the block itself does not enforce it.
module incremental_pid_two_channel
  import ipid2_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [15:0]          in_tdata,   // measured[15:0]
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata,  // drive_a[15:0], drive_b[31:16]
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgAddrW-1:0]  cfg_addr,
  input  logic [CfgDataW-1:0]  cfg_data
);

  cfg_t        cfg_r;
  loop_state_t state_r;
  loop_state_t state_nxt;

  logic                      in_valid_r;
  logic signed [SampleW-1:0] meas_r;
  logic                      out_valid_r;
  logic [DutyW-1:0]          drive_a_r;
  logic [DutyW-1:0]          drive_b_r;

  logic out_load;
  logic advance;

  assign cfg_ready = 1'b1;
  assign out_load  = !out_valid_r || out_tready;
  assign advance   = in_valid_r && out_load;
  assign in_tready = !in_valid_r || advance;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {drive_b_r, drive_a_r};

  ipid2_calc u_calc (
    .cfg       (cfg_r),
    .state_cur (state_r),
    .measured  (meas_r),
    .state_nxt (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint         <= '0;
      cfg_r.gain_now         <= '0;
      cfg_r.gain_last        <= '0;
      cfg_r.gain_before_last <= '0;
      cfg_r.step_max         <= StepW'(65535);
      cfg_r.step_min         <= -StepW'(65536);
      cfg_r.duty_max         <= '1;
      cfg_r.duty_min         <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_SETPOINT:         cfg_r.setpoint         <= cfg_data[SampleW-1:0];
        REG_GAIN_NOW:         cfg_r.gain_now         <= cfg_data[GainW-1:0];
        REG_GAIN_LAST:        cfg_r.gain_last        <= cfg_data[GainW-1:0];
        REG_GAIN_BEFORE_LAST: cfg_r.gain_before_last <= cfg_data[GainW-1:0];
        REG_STEP_MAX:         cfg_r.step_max         <= cfg_data[StepW-1:0];
        REG_STEP_MIN:         cfg_r.step_min         <= cfg_data[StepW-1:0];
        REG_DUTY_MAX:         cfg_r.duty_max         <= cfg_data[DutyW-1:0];
        REG_DUTY_MIN:         cfg_r.duty_min         <= cfg_data[DutyW-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (out_load) begin
        out_valid_r <= in_valid_r;
      end
      // loop state moves only when a sample passes to the output register
      if (advance) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      meas_r <= in_tdata;
    end
    if (advance) begin
      drive_a_r <= state_nxt.acc_a;
      drive_b_r <= state_nxt.acc_b;
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb
  import ipid2_pkg::*;
();

  typedef struct packed {
    logic [15:0] drive_b;
    logic [15:0] drive_a;
  } drive_pair_t;

  class drive_scoreboard;
    logic signed [15:0] setpoint;
    logic signed [15:0] gain_now;
    logic signed [15:0] gain_last;
    logic signed [15:0] gain_before_last;
    logic signed [16:0] step_max;
    logic signed [16:0] step_min;
    logic        [15:0] duty_max;
    logic        [15:0] duty_min;
    logic signed [16:0] err_prev1;
    logic signed [16:0] err_prev2;
    logic        [15:0] acc_a;
    logic        [15:0] acc_b;
    drive_pair_t        expected_drives[$];
    int                 errors;

    function new();
      setpoint         = '0;
      gain_now         = '0;
      gain_last        = '0;
      gain_before_last = '0;
      step_max         = 17'sd65535;
      step_min         = -17'sd65536;
      duty_max         = 16'hffff;
      duty_min         = '0;
      err_prev1        = '0;
      err_prev2        = '0;
      acc_a            = '0;
      acc_b            = '0;
      errors           = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [16:0] value);
      case (idx)
        REG_SETPOINT:         setpoint = value[15:0];
        REG_GAIN_NOW:         gain_now = value[15:0];
        REG_GAIN_LAST:        gain_last = value[15:0];
        REG_GAIN_BEFORE_LAST: gain_before_last = value[15:0];
        REG_STEP_MAX:         step_max = value;
        REG_STEP_MIN:         step_min = value;
        REG_DUTY_MAX:         duty_max = value[15:0];
        REG_DUTY_MIN:         duty_min = value[15:0];
        default: ;
      endcase
    endfunction

    // upper bound tested first, so an inverted clamp gives step_max above it, else step_min
    function longint limit_step(longint v);
      if (v > longint'(step_max)) return longint'(step_max);
      if (v < longint'(step_min)) return longint'(step_min);
      return v;
    endfunction

    function longint limit_duty(longint v);
      if (v >= longint'(duty_max)) return longint'(duty_max);
      if (v <= longint'(duty_min)) return longint'(duty_min);
      return v;
    endfunction

    function void note_sample(logic signed [15:0] measured);
      longint      err;
      longint      raw;
      longint      inc;
      drive_pair_t pair;
      err = longint'(setpoint) - longint'(measured);
      raw = longint'(gain_now) * err - longint'(gain_last) * longint'(err_prev1)
          + longint'(gain_before_last) * longint'(err_prev2);
      inc = raw / 256;  // truncates toward zero
      err_prev2 = err_prev1;
      err_prev1 = err[16:0];
      acc_a = 16'(limit_duty(longint'(acc_a) + limit_step(inc)));
      acc_b = 16'(limit_duty(longint'(acc_b) + limit_step(-inc)));
      pair.drive_a = acc_a;
      pair.drive_b = acc_b;
      expected_drives.push_back(pair);
    endfunction

    function void check_drive(logic [31:0] tdata);
      drive_pair_t want;
      drive_pair_t got;
      got = tdata;
      if (expected_drives.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, tdata);
        errors++;
        return;
      end
      want = expected_drives.pop_front();
      if (got.drive_a !== want.drive_a) begin
        $display("%0t: drive_a expected %0d actual %0d", $time, want.drive_a, got.drive_a);
        errors++;
      end
      if (got.drive_b !== want.drive_b) begin
        $display("%0t: drive_b expected %0d actual %0d", $time, want.drive_b, got.drive_b);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [15:0]         in_tdata;    // measured[15:0]
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [31:0]         out_tdata;   // drive_a[15:0], drive_b[31:16]
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgAddrW-1:0] cfg_addr;
  logic [CfgDataW-1:0] cfg_data;

  drive_scoreboard sb;
  logic            burst;
  int              stall_left = 0;
  logic [15:0]     cur_setpoint;

  incremental_pid_two_channel dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
      if (!burst && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_drive(out_tdata);
  end

  // all driving tasks start and end on a falling edge
  task automatic write_reg(input cfg_reg_t idx, input logic [16:0] value);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_sample(input logic [15:0] value);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    sb.note_sample(value);
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain();
    int count;
    in_tvalid <= 1'b0;
    count = 0;
    while (sb.expected_drives.size() != 0 && count < 20000) begin
      @(negedge clk);
      count++;
    end
    repeat (6) @(negedge clk);
  endtask

  task automatic apply_settings(input int sp, input int gn, input int gl, input int gb,
                                input int smax, input int smin, input int dmax,
                                input int dmin);
    write_reg(REG_SETPOINT, sp[16:0]);
    write_reg(REG_GAIN_NOW, gn[16:0]);
    write_reg(REG_GAIN_LAST, gl[16:0]);
    write_reg(REG_GAIN_BEFORE_LAST, gb[16:0]);
    write_reg(REG_STEP_MAX, smax[16:0]);
    write_reg(REG_STEP_MIN, smin[16:0]);
    write_reg(REG_DUTY_MAX, dmax[16:0]);
    write_reg(REG_DUTY_MIN, dmin[16:0]);
    cur_setpoint = sp[15:0];
  endtask

  function automatic logic [15:0] rand_word16();
    int r;
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3, 4, 5: begin
        r = $urandom_range(0, 2048) - 1024;
        return r[15:0];
      end
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [16:0] rand_step();
    int r;
    case ($urandom_range(0, 5))
      0: return 17'h0ffff;
      1: return 17'h10000;
      2, 3: begin
        r = $urandom_range(0, 4000) - 2000;
        return r[16:0];
      end
      default: return 17'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_duty();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_sample();
    logic [15:0] off;
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2, 3, 4: begin
        off = 16'($urandom_range(0, 128));
        return cur_setpoint + off - 16'd64;
      end
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic signed [16:0] smax, smin, stmp;
    logic        [15:0] dmax, dmin, dtmp;
    logic        [15:0] v;
    drive_pair_t        left;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    cfg_valid    = 1'b0;
    cfg_addr     = REG_SETPOINT;
    cfg_data     = '0;
    burst        = 1'b0;
    cur_setpoint = '0;
    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (3) @(negedge clk);

    // largest errors and gains, drives pinned at the range ends
    apply_settings(32767, 32767, -32768, 32767, 65535, -65536, 65535, 0);
    send_sample(16'h8000);
    send_sample(16'h8000);
    send_sample(16'h7fff);
    send_sample(16'h7fff);
    send_sample(16'h0000);
    send_sample(16'hffff);
    drain();
    apply_settings(-32768, -32768, 32767, -32768, 100, -50, 1000, 200);
    send_sample(16'h7fff);
    send_sample(16'h8000);
    send_sample(16'h0000);
    send_sample(16'h0001);
    send_sample(16'h8000);
    drain();
    // inverted step clamp and inverted duty range
    apply_settings(0, 256, 128, 64, -500, 500, 30000, 40000);
    send_sample(16'd1000);
    send_sample(-16'sd1000);
    send_sample(16'h7fff);
    send_sample(16'h8000);
    send_sample(16'd5);
    drain();
    apply_settings(100, 256, 0, 0, -65536, 65535, 0, 65535);
    send_sample(16'd100);
    send_sample(16'h0000);
    send_sample(16'h8000);
    drain();
    apply_settings(0, 1, -1, 1, 0, 0, 65535, 65535);
    send_sample(16'h7fff);
    send_sample(16'h8000);
    send_sample(16'h0000);
    drain();

    for (int ph = 0; ph < 16; ph++) begin
      burst = ($urandom_range(0, 4) == 0);
      if (ph == 0 || $urandom_range(0, 1)) begin
        v = rand_word16();
        write_reg(REG_SETPOINT, {$urandom_range(0, 1) == 1, v});
        cur_setpoint = v;
      end
      if (ph == 0 || $urandom_range(0, 1))
        write_reg(REG_GAIN_NOW, {$urandom_range(0, 1) == 1, rand_word16()});
      if (ph == 0 || $urandom_range(0, 1))
        write_reg(REG_GAIN_LAST, {$urandom_range(0, 1) == 1, rand_word16()});
      if (ph == 0 || $urandom_range(0, 1))
        write_reg(REG_GAIN_BEFORE_LAST, {$urandom_range(0, 1) == 1, rand_word16()});
      if (ph == 0 || $urandom_range(0, 1)) begin
        smax = rand_step();
        smin = rand_step();
        // mostly a proper window, sometimes left inverted
        if ($urandom_range(0, 7) != 0 && smax < smin) begin
          stmp = smax;
          smax = smin;
          smin = stmp;
        end
        write_reg(REG_STEP_MAX, smax);
        write_reg(REG_STEP_MIN, smin);
      end
      if (ph == 0 || $urandom_range(0, 1)) begin
        dmax = rand_duty();
        dmin = rand_duty();
        if ($urandom_range(0, 7) != 0 && dmax < dmin) begin
          dtmp = dmax;
          dmax = dmin;
          dmin = dtmp;
        end
        write_reg(REG_DUTY_MAX, {$urandom_range(0, 1) == 1, dmax});
        write_reg(REG_DUTY_MIN, {$urandom_range(0, 1) == 1, dmin});
      end
      repeat (100) send_sample(rand_sample());
      drain();
    end

    while (sb.expected_drives.size() != 0) begin
      left = sb.expected_drives.pop_front();
      $display("%0t: missing result, expected drive_a %0d drive_b %0d, actual none",
               $time, left.drive_a, left.drive_b);
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== incremental_pid_two_channel.f =====
hdl/ipid2_pkg.sv
hdl/ipid2_calc.sv
hdl/incremental_pid_two_channel.sv
tb/tb.sv
